>>> hw/rtl/csvsel_pkg.sv
`timescale 1ns / 1ps

package csvsel_pkg;

    // Widths of the stream fields.
    localparam int BYTE_W   = 8;
    localparam int SLOT_W   = 6;
    localparam int COLUMN_W = 7;

    // Column selection.
    localparam int MAX_COLUMNS = 64;
    localparam int MASK_W      = 64;
    localparam int COL_IDX_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    // Saturation limits of the record counters.
    localparam logic [COLUMN_W-1:0] COLUMN_LIMIT = 7'd127;
    localparam logic [SLOT_W-1:0]   SLOT_LIMIT   = 6'd63;

    // Special characters.
    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h22;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

    // Configuration register map.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = MASK_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WANTED_COLUMN_MASK = 1'b0,
        REG_SKIP_HEADER        = 1'b1
    } cfg_reg_t;

    // Result handed from the parser to the output register.
    typedef struct packed {
        logic              valid;
        logic              record_end;
        logic [SLOT_W-1:0] slot_index;
        logic [BYTE_W-1:0] field_byte;
    } result_t;

endpackage

>>> hw/rtl/csvsel_text_if.sv
`timescale 1ns / 1ps

interface csvsel_text_if;

    logic                          valid;
    logic                          ready;
    logic [csvsel_pkg::BYTE_W-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);

endinterface

>>> hw/rtl/csvsel_field_if.sv
`timescale 1ns / 1ps

interface csvsel_field_if;

    logic                          valid;
    logic                          ready;
    logic                          record_end;
    logic [csvsel_pkg::SLOT_W-1:0] slot_index;
    logic [csvsel_pkg::BYTE_W-1:0] field_byte;

    modport source (output valid, output record_end, output slot_index, output field_byte,
                    input ready);
    modport sink (input valid, input record_end, input slot_index, input field_byte,
                  output ready);

endinterface

>>> hw/rtl/csv_column_selector_top.sv
`timescale 1ns / 1ps

// Channel  | Role   | Payload
// ---------+--------+---------------------------------------------------
// text     | sink   | text_byte[7:0]
// field    | source | record_end, slot_index[5:0], field_byte[7:0]
// cfg      | write  | cfg_we, cfg_index[0:0], cfg_data[63:0]
//
// One text transaction is taken in every cycle while the output register has room;
// its result, if any, is there in the next cycle. The parser state and the output
// register update in the same cycle; that single register stage sets the rate.
// Reset clears the record state, the mask and sets skip_header.
// A stall on field holds the result and blocks text only while the register is full.

module csv_column_selector_top (
    input  logic                              clk,
    input  logic                              rst_n,
    csvsel_text_if.sink                       text,
    csvsel_field_if.source                    field,
    input  logic                              cfg_we,
    input  logic [csvsel_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csvsel_pkg::CFG_DATA_W-1:0] cfg_data
);

    import csvsel_pkg::*;

    logic [MASK_W-1:0] wanted_column_mask;
    logic              skip_header;
    logic              space;
    logic              accept;
    result_t           result;

    // An input transaction completes when the output register has room.
    assign text.ready = space;
    assign accept     = text.valid && space;

    csvsel_cfg u_cfg (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .wanted_column_mask (wanted_column_mask),
        .skip_header        (skip_header)
    );

    csvsel_parser u_parser (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .text_byte          (text.text_byte),
        .wanted_column_mask (wanted_column_mask),
        .skip_header        (skip_header),
        .result             (result)
    );

    csvsel_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .result (result),
        .space  (space),
        .field  (field)
    );

endmodule

>>> hw/rtl/csvsel_cfg.sv
`timescale 1ns / 1ps

module csvsel_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [csvsel_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csvsel_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [csvsel_pkg::MASK_W-1:0]     wanted_column_mask,
    output logic                              skip_header
);

    import csvsel_pkg::*;

    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;
    logic              skip_reg;
    logic              skip_next;

    // Register decode: a write updates the addressed register only.
    always_comb
    begin
        mask_next = mask_reg;
        skip_next = skip_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WANTED_COLUMN_MASK: mask_next = cfg_data[MASK_W-1:0];
                REG_SKIP_HEADER:        skip_next = cfg_data[0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            skip_reg <= 1'b1;
        end
        else
        begin
            mask_reg <= mask_next;
            skip_reg <= skip_next;
        end
    end

    assign wanted_column_mask = mask_reg;
    assign skip_header        = skip_reg;

endmodule

>>> hw/rtl/csvsel_parser.sv
`timescale 1ns / 1ps

module csvsel_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [csvsel_pkg::BYTE_W-1:0] text_byte,
    input  logic [csvsel_pkg::MASK_W-1:0] wanted_column_mask,
    input  logic                          skip_header,
    output csvsel_pkg::result_t           result
);

    import csvsel_pkg::*;

    logic                in_quotes_reg;
    logic                in_quotes_next;
    logic [COLUMN_W-1:0] column_number_reg;
    logic [COLUMN_W-1:0] column_number_next;
    logic [SLOT_W-1:0]   slot_counter_reg;
    logic [SLOT_W-1:0]   slot_counter_next;
    logic                header_seen_reg;
    logic                header_seen_next;

    logic is_newline;
    logic is_quote;
    logic is_comma;
    logic in_header;
    logic column_selected;

    // Byte classification and column lookup.
    assign is_newline      = (text_byte == CH_NEWLINE);
    assign is_quote        = (text_byte == CH_QUOTE);
    assign is_comma        = (text_byte == CH_COMMA);
    assign in_header       = skip_header && !header_seen_reg;
    assign column_selected = (column_number_reg < COLUMN_W'(MAX_COLUMNS))
                             && wanted_column_mask[column_number_reg[COL_IDX_W-1:0]];

    // Per-byte state update and result.
    always_comb
    begin
        in_quotes_next     = in_quotes_reg;
        column_number_next = column_number_reg;
        slot_counter_next  = slot_counter_reg;
        header_seen_next   = header_seen_reg;
        result             = '0;

        if (accept)
        begin
            if (is_newline)
            begin
                // A newline ends the record even inside quotes.
                in_quotes_next     = 1'b0;
                column_number_next = '0;
                slot_counter_next  = '0;
                header_seen_next   = 1'b1;
                if (!in_header)
                begin
                    result.valid      = 1'b1;
                    result.record_end = 1'b1;
                end
            end
            else if (!in_header)
            begin
                if (is_quote)
                begin
                    in_quotes_next = !in_quotes_reg;
                end
                else if (is_comma && !in_quotes_reg)
                begin
                    if (column_selected && (slot_counter_reg != SLOT_LIMIT))
                    begin
                        slot_counter_next = slot_counter_reg + 1'b1;
                    end
                    if (column_number_reg != COLUMN_LIMIT)
                    begin
                        column_number_next = column_number_reg + 1'b1;
                    end
                end
                else if (column_selected)
                begin
                    result.valid      = 1'b1;
                    result.slot_index = slot_counter_reg;
                    result.field_byte = text_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg     <= 1'b0;
            column_number_reg <= '0;
            slot_counter_reg  <= '0;
            header_seen_reg   <= 1'b0;
        end
        else
        begin
            in_quotes_reg     <= in_quotes_next;
            column_number_reg <= column_number_next;
            slot_counter_reg  <= slot_counter_next;
            header_seen_reg   <= header_seen_next;
        end
    end

endmodule

>>> hw/rtl/csvsel_out_reg.sv
`timescale 1ns / 1ps

module csvsel_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  csvsel_pkg::result_t   result,
    output logic                  space,
    csvsel_field_if.source        field
);

    import csvsel_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic              record_end_reg;
    logic              record_end_next;
    logic [SLOT_W-1:0] slot_index_reg;
    logic [SLOT_W-1:0] slot_index_next;
    logic [BYTE_W-1:0] field_byte_reg;
    logic [BYTE_W-1:0] field_byte_next;

    // The register can take a new result when it is empty or being drained.
    assign space = !valid_reg || field.ready;

    always_comb
    begin
        valid_next      = valid_reg;
        record_end_next = record_end_reg;
        slot_index_next = slot_index_reg;
        field_byte_next = field_byte_reg;
        if (accept)
        begin
            valid_next      = result.valid;
            record_end_next = result.record_end;
            slot_index_next = result.slot_index;
            field_byte_next = result.field_byte;
        end
        else if (field.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        record_end_reg <= record_end_next;
        slot_index_reg <= slot_index_next;
        field_byte_reg <= field_byte_next;
    end

    assign field.valid      = valid_reg;
    assign field.record_end = record_end_reg;
    assign field.slot_index = slot_index_reg;
    assign field.field_byte = field_byte_reg;

endmodule
